@@ design/rru_pkg.sv @@
// ----------------------------------------------------------------------------
// rru_pkg - register rename unit shared definitions
// Sizes, request and result word layouts, operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rru_pkg;

  // Register file sizes
  localparam int PHYS_REGS    = 64;
  localparam int LOGICAL_REGS = 32;
  localparam int FREE_RST     = PHYS_REGS - LOGICAL_REGS;

  localparam int PHYS_W = $clog2(PHYS_REGS);
  localparam int LOG_W  = $clog2(LOGICAL_REGS);
  localparam int CNT_W  = $clog2(PHYS_REGS + 1);
  localparam int RC_W   = 8;
  localparam int NEED_W = 4;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  localparam logic [RC_W-1:0] RC_MAX = '1;

  // Word widths on the streams
  localparam int IN_W   = 24;
  localparam int OUT_W  = 24;
  localparam int RES_W  = 2 * PHYS_W + 1 + STAT_W + CNT_W;
  localparam int PAD_W  = OUT_W - RES_W;

  typedef enum logic [OP_W-1:0] {
    OP_RENAME_SRC  = 3'd0,
    OP_RENAME_DST  = 3'd1,
    OP_READ_SRC    = 3'd2,
    OP_WRITE_DST   = 3'd3,
    OP_UNDO_DST    = 3'd4,
    OP_COMMIT_DST  = 3'd5,
    OP_READY_QUERY = 3'd6,
    OP_CAN_RENAME  = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RC_OVF  = 2'd2
  } status_t;

  // Request word, first field in the highest bits
  typedef struct packed {
    logic [NEED_W-1:0] need_count;
    logic [PHYS_W-1:0] old_phys_reg;
    logic [PHYS_W-1:0] phys_reg;
    logic [LOG_W-1:0]  logical_reg;
    op_t               req_type;
  } req_t;

  // Result word, first field in the highest bits
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [CNT_W-1:0]  free_count_out;
    status_t           status;
    logic              flag;
    logic [PHYS_W-1:0] prev_phys;
    logic [PHYS_W-1:0] new_phys;
  } res_t;

endpackage

`default_nettype wire

@@ design/register_rename_unit.sv @@
// ----------------------------------------------------------------------------
// register_rename_unit - register renaming with alias table and free stack
// One operand operation per word: rename, read, write, undo, commit, query.
// ----------------------------------------------------------------------------
// The unit takes one request word per clock while its output is taken and
// gives one result word per request, in order. A request is registered on
// acceptance (together with the reader count of the register it touches and
// the alias table entry it names), executed once the output register is free
// or being taken, and its result is then registered in the output register.
// The rate is set by the free-stack update, which must finish in the execute
// cycle before the following request may pop or push. The free stack and
// the reader counts live in single-port-write memories; no clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module register_rename_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // req_type[2:0], logical_reg[7:3], phys_reg[13:8], old_phys_reg[19:14],
  // need_count[23:20]
  input  wire logic [rru_pkg::IN_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // new_phys[5:0], prev_phys[11:6], flag[12], status[14:13],
  // free_count_out[21:15], zero[23:22]
  output logic [rru_pkg::OUT_W-1:0]     out_tdata
);

  import rru_pkg::*;

  // Handshake
  logic in_acc;
  logic out_free;
  logic exec;

  // Request stage
  req_t              in_req;
  logic              s1_vld_r;
  req_t              s1_req_r;
  logic [PHYS_W-1:0] s1_alias_r;

  // Result register
  logic out_vld_r;
  res_t out_data_r;
  res_t res_nxt;

  // Alias table
  logic [PHYS_W-1:0] alias_r [LOGICAL_REGS];
  logic              alias_we;
  logic [LOG_W-1:0]  alias_widx;
  logic [PHYS_W-1:0] alias_wdata;
  logic [PHYS_W-1:0] alias_fwd;

  // Free stack
  logic [PHYS_W-1:0] stk_mem [PHYS_REGS];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  low_mark_r, low_mark_nxt;
  logic              stk_we;
  logic [PHYS_W-1:0] stk_waddr;
  logic [PHYS_W-1:0] stk_wdata;
  logic [PHYS_W-1:0] stk_raddr;
  logic [PHYS_W-1:0] stk_q_r;
  logic              stk_byp_r;
  logic [PHYS_W-1:0] stk_byp_data_r;
  logic              stk_old_r;
  logic [PHYS_W-1:0] stk_addr_r;
  logic [PHYS_W-1:0] top;

  // Reader counts
  logic [RC_W-1:0]      rc_mem [PHYS_REGS];
  logic [PHYS_REGS-1:0] rc_vld_r;
  logic                 rc_we;
  logic [PHYS_W-1:0]    rc_waddr;
  logic [RC_W-1:0]      rc_wdata;
  logic [PHYS_W-1:0]    rc_raddr;
  logic [RC_W-1:0]      rc_q_r;
  logic                 rc_byp_r;
  logic [RC_W-1:0]      rc_byp_data_r;
  logic                 rc_vld_rd_r;
  logic [RC_W-1:0]      rc_s1;
  logic [RC_W-1:0]      rc_dec;
  logic [RC_W-1:0]      rc_after;

  // Per-register status bits
  logic [PHYS_REGS-1:0] remap_r, remap_nxt;
  logic [PHYS_REGS-1:0] cmpl_r, cmpl_nxt;
  logic [PHYS_REGS-1:0] busy_r, busy_nxt;

  // Release check
  logic              rel_chk;
  logic              rel;
  logic [PHYS_W-1:0] tgt;
  logic              tgt_rm;
  logic              tgt_cp;

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // --------------------------------------------------------------------------
  assign out_free  = !out_vld_r || out_tready;
  assign exec      = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign in_req    = req_t'(in_tdata);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Operand lookup on acceptance, forwarding the write of the executing word
  // --------------------------------------------------------------------------
  always_comb begin
    if (alias_we && (alias_widx == in_req.logical_reg)) begin
      alias_fwd = alias_wdata;
    end else begin
      alias_fwd = alias_r[in_req.logical_reg];
    end
    unique case (in_req.req_type)
      OP_RENAME_SRC: rc_raddr = alias_fwd;
      OP_COMMIT_DST: rc_raddr = in_req.old_phys_reg;
      default:       rc_raddr = in_req.phys_reg;
    endcase
  end

  // Top of the free stack: forwarded push, reset contents or memory data
  always_comb begin
    if (stk_byp_r) begin
      top = stk_byp_data_r;
    end else if (stk_old_r) begin
      top = stk_addr_r;
    end else begin
      top = stk_q_r;
    end
  end

  // Reader count of the staged register; never-written entries read zero
  always_comb begin
    if (rc_byp_r) begin
      rc_s1 = rc_byp_data_r;
    end else if (rc_vld_rd_r) begin
      rc_s1 = rc_q_r;
    end else begin
      rc_s1 = '0;
    end
  end

  assign rc_dec = (rc_s1 != '0) ? rc_s1 - RC_W'(1) : '0;

  // --------------------------------------------------------------------------
  // Execute
  // --------------------------------------------------------------------------
  always_comb begin
    res_nxt     = '0;
    count_nxt   = count_r;
    remap_nxt   = remap_r;
    cmpl_nxt    = cmpl_r;
    busy_nxt    = busy_r;
    alias_we    = 1'b0;
    alias_widx  = s1_req_r.logical_reg;
    alias_wdata = top;
    rc_we       = 1'b0;
    rc_waddr    = s1_alias_r;
    rc_wdata    = '0;
    stk_we      = 1'b0;
    stk_waddr   = count_r[PHYS_W-1:0];
    rel_chk     = 1'b0;

    tgt      = (s1_req_r.req_type == OP_COMMIT_DST) ? s1_req_r.old_phys_reg
                                                     : s1_req_r.phys_reg;
    rc_after = (s1_req_r.req_type == OP_READ_SRC) ? rc_dec : rc_s1;
    tgt_rm   = remap_r[tgt] || (s1_req_r.req_type == OP_UNDO_DST)
                            || (s1_req_r.req_type == OP_COMMIT_DST);
    tgt_cp   = cmpl_r[tgt] || (s1_req_r.req_type == OP_WRITE_DST);

    if (exec) begin
      unique case (s1_req_r.req_type)
        OP_RENAME_SRC: begin
          res_nxt.new_phys = s1_alias_r;
          if (rc_s1 == RC_MAX) begin
            res_nxt.status = ST_RC_OVF;
          end else begin
            rc_we    = 1'b1;
            rc_wdata = rc_s1 + RC_W'(1);
          end
        end
        OP_RENAME_DST: begin
          if (count_r == '0) begin
            res_nxt.status = ST_NO_FREE;
          end else begin
            count_nxt         = count_r - CNT_W'(1);
            res_nxt.new_phys  = top;
            res_nxt.prev_phys = s1_alias_r;
            alias_we          = 1'b1;
            rc_we             = 1'b1;
            rc_waddr          = top;
            remap_nxt[top]    = 1'b0;
            cmpl_nxt[top]     = 1'b0;
            busy_nxt[top]     = 1'b1;
          end
        end
        OP_READ_SRC: begin
          rc_we    = 1'b1;
          rc_waddr = s1_req_r.phys_reg;
          rc_wdata = rc_dec;
          rel_chk  = 1'b1;
        end
        OP_WRITE_DST: begin
          cmpl_nxt[tgt] = 1'b1;
          rel_chk       = 1'b1;
        end
        OP_UNDO_DST: begin
          remap_nxt[tgt] = 1'b1;
          rel_chk        = 1'b1;
          alias_we       = 1'b1;
          alias_wdata    = s1_req_r.old_phys_reg;
        end
        OP_COMMIT_DST: begin
          remap_nxt[tgt] = 1'b1;
          rel_chk        = 1'b1;
        end
        OP_READY_QUERY: begin
          res_nxt.flag = cmpl_r[s1_req_r.phys_reg];
        end
        OP_CAN_RENAME: begin
          res_nxt.flag = (CNT_W'(s1_req_r.need_count) <= count_r);
        end
        default: begin
          res_nxt.flag = 1'b0;
        end
      endcase
    end

    // Push the register back once nothing holds it
    rel = rel_chk && (rc_after == '0) && tgt_rm && tgt_cp && busy_r[tgt]
          && (count_r < CNT_W'(PHYS_REGS));
    if (rel) begin
      busy_nxt[tgt] = 1'b0;
      stk_we        = 1'b1;
      count_nxt     = count_r + CNT_W'(1);
    end
    stk_wdata = tgt;

    res_nxt.free_count_out = count_nxt;
  end

  // Next top-of-stack address and lowest fill reached since reset
  assign stk_raddr    = PHYS_W'(count_nxt - CNT_W'(1));
  assign low_mark_nxt = (count_nxt < low_mark_r) ? count_nxt : low_mark_r;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      count_r    <= CNT_W'(FREE_RST);
      low_mark_r <= CNT_W'(FREE_RST);
      stk_byp_r  <= 1'b0;
      stk_old_r  <= 1'b1;
      stk_addr_r <= PHYS_W'(FREE_RST - 1);
      rc_vld_r   <= '0;
      cmpl_r     <= '1;
      for (int i = 0; i < PHYS_REGS; i++) begin
        remap_r[i] <= (i < FREE_RST);
        busy_r[i]  <= (i >= FREE_RST);
      end
      for (int i = 0; i < LOGICAL_REGS; i++) begin
        alias_r[i] <= PHYS_W'(PHYS_REGS - 1 - i);
      end
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (exec) begin
        s1_vld_r <= 1'b0;
      end

      if (exec) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end

      if (exec) begin
        count_r    <= count_nxt;
        low_mark_r <= low_mark_nxt;
        stk_byp_r  <= stk_we && (stk_waddr == stk_raddr);
        stk_old_r  <= (CNT_W'(stk_raddr) < low_mark_nxt);
        stk_addr_r <= stk_raddr;
        remap_r    <= remap_nxt;
        cmpl_r     <= cmpl_nxt;
        busy_r     <= busy_nxt;
      end

      if (rc_we) begin
        rc_vld_r[rc_waddr] <= 1'b1;
      end

      if (alias_we) begin
        alias_r[alias_widx] <= alias_wdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers and memories
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r      <= in_req;
      s1_alias_r    <= alias_fwd;
      rc_q_r        <= rc_mem[rc_raddr];
      rc_byp_r      <= rc_we && (rc_waddr == rc_raddr);
      rc_byp_data_r <= rc_wdata;
      rc_vld_rd_r   <= rc_vld_r[rc_raddr];
    end
    if (rc_we) begin
      rc_mem[rc_waddr] <= rc_wdata;
    end
    if (exec) begin
      out_data_r     <= res_nxt;
      stk_q_r        <= stk_mem[stk_raddr];
      stk_byp_data_r <= stk_wdata;
    end
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb - register rename unit testbench
// Drives request words covering every operation and checks each result word
// against a cycle-free model of the alias table, free stack and per-register
// reader count, remap-valid, completed and busy state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import rru_pkg::*;

  localparam int RANDOM_ITEMS = 275;
  localparam int BURST_ITEMS  = 258;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // One renamed destination still waiting for commit or undo
  typedef struct packed {
    logic [LOG_W-1:0]  logical;
    logic [PHYS_W-1:0] fresh;
    logic [PHYS_W-1:0] prior;
  } rename_rec_t;

  // Stimulus bookkeeping: registers with a pending reader, destinations not
  // yet written, renames not yet retired (oldest first)
  logic [PHYS_W-1:0] src_pending [$];
  logic [PHYS_W-1:0] unwritten [$];
  rename_rec_t       inflight [$];
  int unsigned       n_results;

  // --------------------------------------------------------------------------
  // Scoreboard: rename state model and queue of awaited result words
  // --------------------------------------------------------------------------
  class rename_scoreboard;
    logic [PHYS_W-1:0] alias_map [LOGICAL_REGS];
    logic [PHYS_W-1:0] free_list [PHYS_REGS];
    int unsigned       n_free;
    logic [RC_W-1:0]   readers [PHYS_REGS];
    bit                remap_ok [PHYS_REGS];
    bit                written [PHYS_REGS];
    bit                in_use [PHYS_REGS];
    res_t              awaited [$];
    int unsigned       n_errors;

    // State as it stands after reset
    function new();
      for (int i = 0; i < PHYS_REGS; i++) begin
        free_list[i] = PHYS_W'(i);
        readers[i]   = '0;
        written[i]   = 1'b1;
        remap_ok[i]  = (i < FREE_RST);
        in_use[i]    = (i >= FREE_RST);
      end
      for (int i = 0; i < LOGICAL_REGS; i++)
        alias_map[i] = PHYS_W'(PHYS_REGS - 1 - i);
      n_free   = FREE_RST;
      n_errors = 0;
    endfunction

    // Push a register back once nothing holds it; busy bit stops a double push
    function void try_release(logic [PHYS_W-1:0] p);
      if (readers[p] == 0 && remap_ok[p] && written[p] && in_use[p] &&
          n_free < PHYS_REGS) begin
        in_use[p]         = 1'b0;
        free_list[n_free] = p;
        n_free++;
      end
    endfunction

    // Apply one accepted request and queue the result word it must produce
    function res_t note_request(req_t r);
      res_t              res;
      logic [PHYS_W-1:0] p;
      res        = '0;
      res.status = ST_OK;
      case (r.req_type)
        OP_RENAME_SRC: begin
          p            = alias_map[r.logical_reg];
          res.new_phys = p;
          // saturate rather than wrap
          if (readers[p] == RC_MAX)
            res.status = ST_RC_OVF;
          else
            readers[p]++;
        end
        OP_RENAME_DST: begin
          if (n_free == 0) begin
            res.status = ST_NO_FREE;
          end else begin
            n_free--;
            p                         = free_list[n_free];
            readers[p]                = '0;
            remap_ok[p]               = 1'b0;
            written[p]                = 1'b0;
            in_use[p]                 = 1'b1;
            res.prev_phys             = alias_map[r.logical_reg];
            res.new_phys              = p;
            alias_map[r.logical_reg]  = p;
          end
        end
        OP_READ_SRC: begin
          if (readers[r.phys_reg] != 0)
            readers[r.phys_reg]--;
          try_release(r.phys_reg);
        end
        OP_WRITE_DST: begin
          written[r.phys_reg] = 1'b1;
          try_release(r.phys_reg);
        end
        OP_UNDO_DST: begin
          remap_ok[r.phys_reg] = 1'b1;
          try_release(r.phys_reg);
          alias_map[r.logical_reg] = r.old_phys_reg;
        end
        OP_COMMIT_DST: begin
          remap_ok[r.old_phys_reg] = 1'b1;
          try_release(r.old_phys_reg);
        end
        OP_READY_QUERY: begin
          res.flag = written[r.phys_reg];
        end
        default: begin
          res.flag = (r.need_count <= n_free);
        end
      endcase
      res.free_count_out = CNT_W'(n_free);
      awaited.push_back(res);
      return res;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        n_errors++;
      end
    endfunction

    // Check one accepted result word against the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("result word with no request outstanding: %h", got);
        n_errors++;
      end else begin
        want = awaited.pop_front();
        compare_field("new_phys", want.new_phys, got.new_phys);
        compare_field("prev_phys", want.prev_phys, got.prev_phys);
        compare_field("flag", want.flag, got.flag);
        compare_field("status", want.status, got.status);
        compare_field("free_count_out", want.free_count_out, got.free_count_out);
        compare_field("pad", want.pad, got.pad);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  rename_scoreboard sb = new();

  register_rename_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Sender gap: mostly none, some short, a few long
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60)
      return 0;
    else if (roll < 92)
      return $urandom_range(3, 1);
    else
      return $urandom_range(30, 8);
  endfunction

  function automatic req_t mk_req(op_t op, int lr, int pr, int opr, int need);
    req_t r;
    r.req_type     = op;
    r.logical_reg  = LOG_W'(lr);
    r.phys_reg     = PHYS_W'(pr);
    r.old_phys_reg = PHYS_W'(opr);
    r.need_count   = NEED_W'(need);
    return r;
  endfunction

  // Pick the next request. Mostly well-formed rename traffic drawn from the
  // bookkeeping queues; phase 1 drains the free stack, phase 2 retires
  function automatic req_t pick_request(int phase);
    req_t r;
    int   wt [8];
    int   total;
    int   roll;
    int   idx;
    op_t  kind;
    rename_rec_t rec;
    // random content everywhere; unused fields still toggle
    r = req_t'(IN_W'($urandom));
    case (phase)
      1: wt = '{15, 45, 12, 15, 2, 0, 6, 6};
      2: wt = '{10, 5, 15, 20, 8, 30, 6, 6};
      default: wt = '{15, 15, 15, 15, 5, 15, 6, 6};
    endcase
    total = 8;
    foreach (wt[k]) total += wt[k];
    roll = $urandom_range(total - 1);
    // noise: fully random word
    if (roll < 8)
      return r;
    roll -= 8;
    kind = OP_RENAME_SRC;
    for (int k = 0; k < 8; k++) begin
      if (roll < wt[k]) begin
        kind = op_t'(k);
        break;
      end
      roll -= wt[k];
    end
    if ((kind == OP_UNDO_DST || kind == OP_COMMIT_DST) && inflight.size() == 0)
      kind = OP_READY_QUERY;
    case (kind)
      OP_READ_SRC: begin
        if (src_pending.size() != 0) begin
          idx        = $urandom_range(src_pending.size() - 1);
          r.phys_reg = src_pending[idx];
          src_pending.delete(idx);
        end
      end
      OP_WRITE_DST: begin
        if (unwritten.size() != 0) begin
          idx        = $urandom_range(unwritten.size() - 1);
          r.phys_reg = unwritten[idx];
          unwritten.delete(idx);
        end
      end
      // undo unwinds the youngest rename so the alias entry is restored
      OP_UNDO_DST: begin
        rec            = inflight.pop_back();
        r.logical_reg  = rec.logical;
        r.phys_reg     = rec.fresh;
        r.old_phys_reg = rec.prior;
      end
      // commit retires the oldest rename, freeing its previous mapping
      OP_COMMIT_DST: begin
        rec            = inflight.pop_front();
        r.old_phys_reg = rec.prior;
      end
      OP_READY_QUERY: begin
        if (unwritten.size() != 0 && $urandom_range(1))
          r.phys_reg = unwritten[$urandom_range(unwritten.size() - 1)];
      end
      default: ;
    endcase
    r.req_type = kind;
    return r;
  endfunction

  // Offer one word, wait for the handshake, note it, then idle for gap cycles
  task automatic send_request(input req_t r, input int gap);
    res_t want;
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    want = sb.note_request(r);
    case (r.req_type)
      OP_RENAME_SRC: begin
        if (want.status == ST_OK && src_pending.size() < 48)
          src_pending.push_back(want.new_phys);
      end
      OP_RENAME_DST: begin
        if (want.status == ST_OK) begin
          unwritten.push_back(want.new_phys);
          inflight.push_back('{r.logical_reg, want.new_phys, want.prev_phys});
        end
      end
      default: ;
    endcase
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: random stalls, quiet stretches, one long hold-off
  initial begin : result_sink
    int   hold;
    int   cyc;
    int   roll;
    bit   quiet;
    bit   held_long;
    res_t word;
    hold      = 0;
    cyc       = 0;
    quiet     = 1'b0;
    held_long = 1'b0;
    n_results = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      cyc++;
      if (out_tvalid === 1'b1 && out_tready) begin
        word = out_tdata;
        sb.check_result(word);
        n_results++;
      end
      if (cyc % 200 == 0)
        quiet = ($urandom_range(2) == 0);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (!held_long && n_results >= 120) begin
        // long back-pressure so the unit fills and stalls its input
        held_long = 1'b1;
        hold      = 119;
        out_tready <= 1'b0;
      end else begin
        roll = $urandom_range(99);
        if (quiet || roll < 70) begin
          out_tready <= 1'b1;
        end else if (roll < 95) begin
          hold = $urandom_range(2);
          out_tready <= 1'b0;
        end else begin
          hold = $urandom_range(29, 9);
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int  phase;
    bit  quiet;
    int  burst_lr;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and each operation from a known state
    send_request(mk_req(OP_CAN_RENAME, 0, 0, 0, 0), idle_gap());
    send_request(mk_req(OP_CAN_RENAME, 31, 63, 63, 15), idle_gap());
    send_request(mk_req(OP_READY_QUERY, 0, 0, 0, 0), idle_gap());
    send_request(mk_req(OP_READY_QUERY, 31, 63, 63, 15), idle_gap());
    send_request(mk_req(OP_RENAME_SRC, 0, 0, 0, 0), idle_gap());
    send_request(mk_req(OP_RENAME_SRC, 31, 0, 0, 0), idle_gap());
    send_request(mk_req(OP_RENAME_DST, 31, 0, 0, 0), idle_gap());
    send_request(mk_req(OP_READY_QUERY, 0, 31, 0, 0), idle_gap());
    send_request(mk_req(OP_WRITE_DST, 0, 31, 0, 0), idle_gap());
    send_request(mk_req(OP_READ_SRC, 0, 32, 0, 0), idle_gap());
    // reader count already zero: must not wrap
    send_request(mk_req(OP_READ_SRC, 0, 32, 0, 0), idle_gap());
    send_request(mk_req(OP_COMMIT_DST, 0, 0, 32, 0), idle_gap());
    send_request(mk_req(OP_RENAME_DST, 5, 0, 0, 0), idle_gap());
    // undo before the write: register only freed once written
    send_request(mk_req(OP_UNDO_DST, 5, 32, 58, 0), idle_gap());
    send_request(mk_req(OP_WRITE_DST, 0, 32, 0, 0), idle_gap());
    send_request(mk_req(OP_RENAME_SRC, 5, 0, 0, 0), idle_gap());
    send_request(mk_req(OP_READ_SRC, 0, 63, 0, 0), idle_gap());
    src_pending.delete();
    unwritten.delete();
    inflight.delete();

    // Random: balanced, draining and retiring phases in turn
    quiet = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) begin
        phase = (i / 60) % 3;
        quiet = ($urandom_range(3) == 0);
      end
      // reader count overflow: one logical register read far past saturation
      if (i == 250) begin
        burst_lr = $urandom_range(LOGICAL_REGS - 1);
        for (int k = 0; k < BURST_ITEMS; k++)
          send_request(mk_req(OP_RENAME_SRC, burst_lr, $urandom_range(63),
                              $urandom_range(63), $urandom_range(15)), 0);
      end
      send_request(pick_request(phase), quiet ? 0 : idle_gap());
    end
    in_tvalid <= 1'b0;

    // Let the last result words through, then idle before finishing
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
